@@ rtl/setrig_pkg.sv @@
// ============================================================================
// Edge trigger search package
// Shared types, register map and reset values for the trigger search block.
// ============================================================================
package setrig_pkg;

    // Default ring depth; the ring depth must be a power of two.
    localparam int BUFFER_DEPTH_DEF = 32768;

    // Configuration port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_TRIGGER_LEVEL = 2'd0;
    localparam logic [1:0] REG_RISING_MODE   = 2'd1;
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd2;

    // Register reset values.
    localparam logic [15:0] LEVEL_RESET  = 16'd0;
    localparam logic        MODE_RESET   = 1'b1;
    localparam logic [14:0] WINDOW_RESET = 15'd1024;

    // Item commands.
    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // One input beat.
    typedef struct packed {
        logic               cmd;
        logic [14:0]        sample_addr;
        logic signed [15:0] sample_value;
        logic [14:0]        read_position;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic        found;
        logic [14:0] trigger_index;
    } out_item_t;

    // Register contents handed to the search engine.
    typedef struct packed {
        logic signed [15:0] trigger_level;
        logic               rising_edge_mode;
        logic [14:0]        window_length;
    } cfg_t;

endpackage

@@ rtl/scope_edge_trigger_search.sv @@
// ============================================================================
// Scope edge trigger search
// Ring of Q1.15 samples with a backward edge search for display triggering.
// ============================================================================
//
//  Channel  | Signals                                  | Handshake
//  ---------+------------------------------------------+-----------------------
//  item     | start, busy, item                        | start && !busy
//  result   | done, result                             | done, one cycle
//  config   | psel penable pwrite paddr pwdata prdata  | APB, pready always 1
//
// A store beat writes the ring directly and the block stays ready, so stores
// can follow every cycle while no search runs. A search beat holds busy while
// it scans up to W+1 samples (W = clamped window, 1..BUFFER_DEPTH/2), paced by
// the single read port of the ring: one sample is read per cycle, through a
// registered read. The result strobe follows the last examined sample; an
// early hit ends the search at once. Reset is asynchronous and clears control
// state only; the ring contents stay undefined until written. The receiver
// cannot stall. BUFFER_DEPTH must be a power of two.
//
module scope_edge_trigger_search
    import setrig_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_item_t           item,
    output logic               done,
    output out_item_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int HALF = BUFFER_DEPTH / 2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    cfg_t cfg;

    logic                state_reg, state_next;
    logic [AW-1:0]       w_reg, w_next;
    logic [AW-1:0]       rp_reg, rp_next;
    logic [AW-1:0]       off_reg, off_next;
    logic [AW-1:0]       off_d_reg, off_d_next;
    logic [AW:0]         cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic                seen_low_reg, seen_low_next;
    logic                seen_high_reg, seen_high_next;
    logic                done_reg, done_next;
    out_item_t           result_reg, result_next;

    logic [15:0]         ring_mem [BUFFER_DEPTH];
    logic [15:0]         rd_data_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;

    logic                accept;
    logic [31:0]         win_raw;
    logic [AW-1:0]       win_eff;
    logic [AW-1:0]       off_dec;
    logic signed [15:0]  cur;
    logic                is_low, is_high, hit, last;

    setrig_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = (state_reg == ST_SCAN);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // Window clamp: zero reads as one, anything past half the ring is capped.
    always_comb
    begin
        win_raw = 32'(cfg.window_length);
        if (win_raw == 32'd0)
        begin
            win_eff = AW'(1);
        end
        else if (win_raw > 32'(HALF))
        begin
            win_eff = AW'(HALF);
        end
        else
        begin
            win_eff = AW'(win_raw);
        end
    end

    // Store beats write the ring directly.
    assign wr_en   = accept && (item.cmd == CMD_STORE);
    assign wr_addr = AW'(item.sample_addr);

    // Read issue: step the offset down and fetch the matching sample.
    assign off_dec = off_reg - AW'(1);
    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg <= {1'b0, w_reg});
    assign rd_addr = off_dec + (w_reg >> 1) + rp_reg;

    // Single-port ring storage with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= item.sample_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Compare the returned sample against the level.
    assign cur     = $signed(rd_data_reg);
    assign is_low  = cur < cfg.trigger_level;
    assign is_high = cur > cfg.trigger_level;
    assign hit     = (is_low && seen_high_reg && !cfg.rising_edge_mode) ||
                     (is_high && seen_low_reg && cfg.rising_edge_mode);
    assign last    = cnt_reg > {1'b0, w_reg};

    // Search sequencer.
    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        rp_next        = rp_reg;
        off_next       = off_reg;
        off_d_next     = off_d_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        seen_low_next  = seen_low_reg;
        seen_high_next = seen_high_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_SEARCH))
                begin
                    state_next     = ST_SCAN;
                    w_next         = win_eff;
                    rp_next        = AW'(item.read_position);
                    off_next       = AW'(0) - win_eff;
                    cnt_next       = '0;
                    seen_low_next  = 1'b0;
                    seen_high_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    off_next   = off_dec;
                    off_d_next = off_dec;
                    cnt_next   = cnt_reg + (AW+1)'(1);
                    pend_next  = 1'b1;
                end
                if (pend_reg)
                begin
                    seen_low_next  = seen_low_reg || is_low;
                    seen_high_next = seen_high_reg || is_high;
                    if (hit)
                    begin
                        state_next                = ST_IDLE;
                        pend_next                 = 1'b0;
                        done_next                 = 1'b1;
                        result_next.found         = 1'b1;
                        result_next.trigger_index = 15'(off_d_reg + rp_reg);
                    end
                    else if (last)
                    begin
                        state_next                = ST_IDLE;
                        pend_next                 = 1'b0;
                        done_next                 = 1'b1;
                        result_next.found         = 1'b0;
                        result_next.trigger_index = 15'(off_d_reg);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            seen_low_reg  <= 1'b0;
            seen_high_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            seen_low_reg  <= seen_low_next;
            seen_high_reg <= seen_high_next;
            done_reg      <= done_next;
        end
    end

    // Search context and result payload.
    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        rp_reg     <= rp_next;
        off_reg    <= off_next;
        off_d_reg  <= off_d_next;
        result_reg <= result_next;
    end

    // A result beat always coincides with the block being ready again.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while search still running");

    // A search beat always starts a scan.
    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd == CMD_SEARCH)) |=> busy)
        else $error("search beat did not start a scan");

    // The scan never reads more than window plus one samples.
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (cnt_reg <= ({1'b0, w_reg} + (AW+1)'(1))))
        else $error("scan read past the window");

    // Returned read data is only evaluated during a scan.
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy)
        else $error("pending sample outside a scan");

endmodule

@@ rtl/setrig_regs.sv @@
// ============================================================================
// Edge trigger search register file
// APB-style configuration registers: trigger level, edge mode, window length.
// ============================================================================
module setrig_regs
    import setrig_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [15:0] level_reg;
    logic        mode_reg;
    logic [14:0] window_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes take effect at the access beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= LEVEL_RESET;
            mode_reg   <= MODE_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TRIGGER_LEVEL: level_reg  <= pwdata[15:0];
                REG_RISING_MODE:   mode_reg   <= pwdata[0];
                REG_WINDOW_LENGTH: window_reg <= pwdata[14:0];
                default:           ;
            endcase
        end
    end

    // Read mux returns the stored values, zero-extended.
    always_comb
    begin
        case (reg_idx)
            REG_TRIGGER_LEVEL: prdata = PDATA_W'(level_reg);
            REG_RISING_MODE:   prdata = PDATA_W'(mode_reg);
            REG_WINDOW_LENGTH: prdata = PDATA_W'(window_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.trigger_level    = $signed(level_reg);
    assign cfg.rising_edge_mode = mode_reg;
    assign cfg.window_length    = window_reg;

endmodule
